[src/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded deque with delete by value.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int KIND_W = 3;
    localparam int STAT_W = 2;
    localparam int ECNT_W = 5;

    localparam logic [KIND_W-1:0] KIND_INS_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INS_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REM_FRONT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REM_BACK  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REM_MATCH = 3'd4;

    localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOMATCH = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [ECNT_W-1:0] entry_count;
        logic [STAT_W-1:0] status;
    } out_item_t;

    typedef struct packed {
        logic shift_left;
        logic shift_right;
        logic load_back;
        logic match_del;
    } cell_ctrl_t;

endpackage

[src/bdq_cell.sv]
// ----------------------------------------------------------------------------
// bdq_cell
// One list position: holds an entry, compares it, shifts to either neighbor.
// ----------------------------------------------------------------------------
module bdq_cell
    import bdq_pkg::*;
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [DATA_W-1:0] value,
    input  logic              in_range,
    input  logic              is_back,
    input  logic [DATA_W-1:0] left_data,
    input  logic [DATA_W-1:0] right_data,
    input  logic              match_in,
    output logic              match_out,
    output logic [DATA_W-1:0] data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    assign match_out = match_in | (in_range && (data_reg == value));
    assign data      = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift_right)
        begin
            data_next = left_data;
        end
        else if (ctrl.shift_left || (ctrl.match_del && match_out))
        begin
            data_next = right_data;
        end
        else if (ctrl.load_back && is_back)
        begin
            data_next = value;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

[src/bounded_deque_with_value_delete_core.sv]
// ----------------------------------------------------------------------------
// bounded_deque_with_value_delete_core
// Double-ended queue of up to DEPTH signed values with delete by value.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready/in_data carries one item: a kind (insert
// front, insert back, remove front, remove back, remove first match) and a
// value. Output channel out_valid/out_ready/out_data returns one item per
// input item with the entry count after the operation and a status.
// All cells compare against the value and shift in the same clock, with
// the first-match flag rippling along the cell row.
// The result is held in the output register from the cycle after acceptance.
// A new item is taken in the cycle its predecessor's result is taken, so
// one item per cycle is sustained while the receiver keeps up.
// When the receiver stalls, the result holds and in_ready drops.
// Reset empties the list and clears the output valid; entry contents are
// left as they are and never read before being written.
// ----------------------------------------------------------------------------
module bounded_deque_with_value_delete_core
    import bdq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic [CNT_W-1:0]  occ_reg;
    logic [CNT_W-1:0]  occ_next;
    logic              out_valid_reg;
    out_item_t         out_data_reg;
    logic [STAT_W-1:0] status;
    logic              accept;
    logic              full;
    logic              empty;
    logic              found;
    cell_ctrl_t        ctrl;

    logic [DATA_W-1:0] cell_data [DEPTH];
    logic [DEPTH:0]    match_chain;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign full      = (occ_reg == CNT_W'(DEPTH));
    assign empty     = (occ_reg == '0);
    assign found     = match_chain[DEPTH];
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign match_chain[0] = 1'b0;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [DATA_W-1:0] left_d;
            logic [DATA_W-1:0] right_d;

            if (i == 0)
            begin : g_first
                assign left_d = in_data.value;
            end
            else
            begin : g_mid
                assign left_d = cell_data[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign right_d = in_data.value;
            end
            else
            begin : g_inner
                assign right_d = cell_data[i+1];
            end

            bdq_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .value      (in_data.value),
                .in_range   (CNT_W'(i) < occ_reg),
                .is_back    (CNT_W'(i) == occ_reg),
                .left_data  (left_d),
                .right_data (right_d),
                .match_in   (match_chain[i]),
                .match_out  (match_chain[i+1]),
                .data       (cell_data[i])
            );
        end
    endgenerate

    always_comb
    begin
        ctrl.shift_left  = 1'b0;
        ctrl.shift_right = 1'b0;
        ctrl.load_back   = 1'b0;
        ctrl.match_del   = 1'b0;
        occ_next         = occ_reg;
        status           = STAT_DONE;
        unique case (in_data.kind)
            KIND_INS_FRONT:
            begin
                if (full)
                begin
                    status = STAT_FULL;
                end
                else
                begin
                    ctrl.shift_right = accept;
                    occ_next         = occ_reg + 1'b1;
                end
            end
            KIND_INS_BACK:
            begin
                if (full)
                begin
                    status = STAT_FULL;
                end
                else
                begin
                    ctrl.load_back = accept;
                    occ_next       = occ_reg + 1'b1;
                end
            end
            KIND_REM_FRONT:
            begin
                if (empty)
                begin
                    status = STAT_EMPTY;
                end
                else
                begin
                    ctrl.shift_left = accept;
                    occ_next        = occ_reg - 1'b1;
                end
            end
            KIND_REM_BACK:
            begin
                if (empty)
                begin
                    status = STAT_EMPTY;
                end
                else
                begin
                    occ_next = occ_reg - 1'b1;
                end
            end
            KIND_REM_MATCH:
            begin
                if (empty)
                begin
                    status = STAT_EMPTY;
                end
                else if (!found)
                begin
                    status = STAT_NOMATCH;
                end
                else
                begin
                    ctrl.match_del = accept;
                    occ_next       = occ_reg - 1'b1;
                end
            end
            default:
            begin
                status = STAT_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                occ_reg       <= occ_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result until taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg.entry_count <= ECNT_W'(occ_next);
            out_data_reg.status      <= status;
        end
    end

endmodule
